// ----- src/tcbc_pkg.sv -----
// Shared types, constants and the TEA round function of the TEA CBC encryption unit.
`default_nettype none

package tcbc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ROUNDS = 32;
  localparam int unsigned CNT_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
  localparam int unsigned NKEYS  = 4;
  localparam int unsigned CFG_IDX_W = $clog2(NKEYS);

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t TEA_DELTA = 32'h9e37_79b9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0 = 2'd0,
    CFG_KEY1 = 2'd1,
    CFG_KEY2 = 2'd2,
    CFG_KEY3 = 2'd3
  } cfg_idx_t;

  typedef word_t [NKEYS-1:0] key_t;

  typedef struct packed {
    word_t plain_a;
    word_t plain_b;
    logic  first;
  } item_t;

  typedef struct packed {
    word_t a;
    word_t b;
  } word_pair_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic holding;
  } core_stat_t;

  // One full TEA round: word a is updated first, and the new a feeds word b.
  function automatic word_pair_t tea_round(word_t a, word_t b, word_t sum, key_t k);
    word_pair_t res;
    word_t      na;
    word_t      nb;
    na = a + (((b << 4) + k[0]) ^ (b + sum) ^ ((b >> 5) + k[1]));
    nb = b + (((na << 4) + k[2]) ^ (na + sum) ^ ((na >> 5) + k[3]));
    res.a = na;
    res.b = nb;
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/tcbc_if.sv -----
// Valid/ready channel interfaces for plaintext blocks and ciphertext results.
`default_nettype none

interface tcbc_in_if;
  logic                 valid;
  logic                 ready;
  tcbc_pkg::word_t      plain_word_a;
  tcbc_pkg::word_t      plain_word_b;
  logic                 first_block;

  modport source (output valid, output plain_word_a, output plain_word_b,
                  output first_block, input ready);
  modport sink   (input valid, input plain_word_a, input plain_word_b,
                  input first_block, output ready);
endinterface

interface tcbc_out_if;
  logic                 valid;
  logic                 ready;
  tcbc_pkg::word_t      cipher_word_a;
  tcbc_pkg::word_t      cipher_word_b;

  modport source (output valid, output cipher_word_a, output cipher_word_b, input ready);
  modport sink   (input valid, input cipher_word_a, input cipher_word_b, output ready);
endinterface

`default_nettype wire

// ----- src/tcbc_front.sv -----
// Front end: takes plaintext block transfers into a short queue ahead of the round engine.
`default_nettype none

module tcbc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  tcbc_in_if.sink                in_ch,
  output tcbc_pkg::item_t        q_item,
  output logic                   q_valid,
  input  wire logic              q_pop,
  output tcbc_pkg::q_stat_t      q_stat
);

  tcbc_pkg::item_t                 mem_r [tcbc_pkg::QDEPTH];
  logic [tcbc_pkg::QIDX_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tcbc_pkg::QIDX_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tcbc_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                            push;
  logic                            pop;
  tcbc_pkg::item_t                 in_item;

  assign in_ch.ready = (count_r != tcbc_pkg::QCNT_W'(tcbc_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && q_valid;

  // Only bit 0 of the flag exists on the port; the flag is stored as is.
  assign in_item.plain_a = in_ch.plain_word_a;
  assign in_item.plain_b = in_ch.plain_word_b;
  assign in_item.first   = in_ch.first_block;

  assign q_valid      = (count_r != '0);
  assign q_item       = mem_r[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.full  = !in_ch.ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tcbc_pkg::QIDX_W'(tcbc_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tcbc_pkg::QIDX_W'(tcbc_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- src/tcbc_core.sv -----
// Back end: chaining, the iterated TEA round unit and the result register.
`default_nettype none

module tcbc_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tcbc_pkg::item_t   q_item,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire tcbc_pkg::key_t    key,
  tcbc_out_if.source             out_ch,
  output tcbc_pkg::core_stat_t   core_stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t                        state_r, state_nxt;
  tcbc_pkg::word_t               a_r, a_nxt;
  tcbc_pkg::word_t               b_r, b_nxt;
  tcbc_pkg::word_t               sum_r, sum_nxt;
  logic [tcbc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  tcbc_pkg::word_t               chain_a_r, chain_a_nxt;
  tcbc_pkg::word_t               chain_b_r, chain_b_nxt;
  tcbc_pkg::word_t               out_a_r, out_a_nxt;
  tcbc_pkg::word_t               out_b_r, out_b_nxt;
  logic                          out_valid_r, out_valid_nxt;
  tcbc_pkg::word_pair_t          round;
  tcbc_pkg::word_pair_t          fin;
  logic                          finish;
  logic                          try_load;
  logic                          out_free;
  logic                          last_round;

  assign round      = tcbc_pkg::tea_round(a_r, b_r, sum_r, key);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign last_round = (cnt_r == tcbc_pkg::CNT_W'(tcbc_pkg::ROUNDS - 1));

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    chain_a_nxt   = chain_a_r;
    chain_b_nxt   = chain_b_r;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    finish        = 1'b0;
    try_load      = 1'b0;
    fin.a         = a_r;
    fin.b         = b_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        try_load = 1'b1;
      end
      ST_RUN: begin
        a_nxt   = round.a;
        b_nxt   = round.b;
        sum_nxt = sum_r + tcbc_pkg::TEA_DELTA;
        cnt_nxt = cnt_r + 1'b1;
        if (last_round) begin
          if (out_free) begin
            finish   = 1'b1;
            fin      = round;
            try_load = 1'b1;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          finish   = 1'b1;
          try_load = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      out_a_nxt     = fin.a;
      out_b_nxt     = fin.b;
      out_valid_nxt = 1'b1;
      chain_a_nxt   = fin.a;
      chain_b_nxt   = fin.b;
      state_nxt     = ST_IDLE;
    end

    // A waiting block starts in the same cycle as the previous one finishes.
    if (try_load && q_valid) begin
      q_pop     = 1'b1;
      a_nxt     = q_item.plain_a ^ (q_item.first ? '0 : chain_a_nxt);
      b_nxt     = q_item.plain_b ^ (q_item.first ? '0 : chain_b_nxt);
      sum_nxt   = tcbc_pkg::TEA_DELTA;
      cnt_nxt   = '0;
      state_nxt = ST_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      chain_a_r   <= '0;
      chain_b_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chain_a_r   <= chain_a_nxt;
      chain_b_r   <= chain_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    sum_r   <= sum_nxt;
    out_a_r <= out_a_nxt;
    out_b_r <= out_b_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cipher_word_a = out_a_r;
  assign out_ch.cipher_word_b = out_b_r;

  assign core_stat.busy    = (state_r != ST_IDLE);
  assign core_stat.holding = (state_r == ST_HOLD);

endmodule

`default_nettype wire

// ----- src/tea_cbc_encrypt_unit.sv -----
// Top level of the TEA CBC encryption unit: key registers, front queue and round engine.
`default_nettype none

// This unit encrypts 64-bit blocks with TEA in CBC mode, starting from an all-zero
// chaining value. Each transfer on in_ch carries two 32-bit plaintext words and a
// first_block flag; a set flag clears the chaining words before that block, so it
// starts a new message. Each word is XORed with the matching word of the previous
// ciphertext and then goes through 32 TEA rounds under the 128-bit key held in four
// registers, written through the cfg_ port (index 0 to 3 selects key word 0 to 3;
// they reset to zero and should only be written while the unit is idle). The two
// ciphertext words leave as one transfer on out_ch and are kept for chaining. One
// round unit is used 32 times per block, one round per clock. A two-entry queue in front
// of the engine and the result register behind it let both sides stall independently:
// the next block is taken while the engine works and while a result still waits.

module tea_cbc_encrypt_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  tcbc_in_if.sink                                   in_ch,
  tcbc_out_if.source                                out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [tcbc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire tcbc_pkg::word_t                      cfg_wdata
);

  tcbc_pkg::key_t        key_r, key_nxt;
  tcbc_pkg::item_t       q_item;
  logic                  q_valid;
  logic                  q_pop;
  tcbc_pkg::q_stat_t     q_stat;
  tcbc_pkg::core_stat_t  core_stat;

  // Key register file. Every index of the port maps onto one key word.
  always_comb begin
    key_nxt = key_r;
    if (cfg_we) begin
      unique case (tcbc_pkg::cfg_idx_t'(cfg_idx))
        tcbc_pkg::CFG_KEY0: key_nxt[0] = cfg_wdata;
        tcbc_pkg::CFG_KEY1: key_nxt[1] = cfg_wdata;
        tcbc_pkg::CFG_KEY2: key_nxt[2] = cfg_wdata;
        tcbc_pkg::CFG_KEY3: key_nxt[3] = cfg_wdata;
        default: key_nxt = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  // The front queue accepts blocks while the engine is still busy.
  tcbc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_stat  (q_stat)
  );

  // The engine applies chaining, runs the rounds and holds the result.
  tcbc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .key       (key_r),
    .out_ch    (out_ch),
    .core_stat (core_stat)
  );

  // The queue never holds more blocks than it has entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= tcbc_pkg::QCNT_W'(tcbc_pkg::QDEPTH))
    else $error("queue count exceeds its depth");

  // Input is only held off when the queue is full.
  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_stat.count == tcbc_pkg::QCNT_W'(tcbc_pkg::QDEPTH))
    else $error("input stalled while the queue has room");

  // An idle engine picks up a waiting block in the next cycle.
  a_no_idle_with_work: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.count != '0 && !core_stat.busy) |=> core_stat.busy)
    else $error("engine stayed idle with a block waiting");

  // While the engine holds a finished block, the result register is occupied.
  a_hold_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    core_stat.holding |-> out_ch.valid)
    else $error("engine holding a result with an empty output register");

endmodule

`default_nettype wire
